@@ design/stm_pkg.sv @@
// Shared types and constants for the sphere-tracing ray marcher.
// Used by stm_ctrl, stm_dp and sphere_trace_ray_marcher_top.
package stm_pkg;

	localparam int MAX_SPHERES = 8;
	localparam int FRAC_BITS   = 16;
	localparam int SLOT_W      = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int K_W         = SLOT_W + 1;
	localparam int ISQRT_STEPS = 32;
	localparam int ITER_W      = $clog2(ISQRT_STEPS);

	localparam logic [1:0] CFG_STEP_LIMIT = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
	localparam logic [1:0] CFG_FAR_LIMIT  = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RAY  = 1'b1;

	typedef struct packed {
		logic              ld_ray;
		logic              ld_sph;
		logic              pt_mul;
		logic              pt_wr;
		logic              sq_mul;
		logic              acc_clr;
		logic              acc;
		logic              root_init;
		logic              root_step;
		logic              best_init;
		logic              best_upd;
		logic              trav_upd;
		logic              out_wr;
		logic [1:0]        axis;
		logic [SLOT_W-1:0] slot;
		logic [8:0]        count;
	} stm_cmd_t;

	typedef struct packed {
		logic       slot_valid;
		logic       stop;
		logic       out_busy;
		logic [7:0] step_limit;
	} stm_stat_t;

endpackage

@@ design/sphere_trace_ray_marcher_top.sv @@
// Per step of a ray: three point products on the shared multiplier, a scan of the sphere
// slots and a stop decision; each valid sphere costs a scan step, three squarings on the
// shared multiplier, a root setup, a bit-serial square root and a compare.
// One ray at a time; the next word is taken while a result waits in the output
// register, which holds the ray in ST_DONE until it frees.
// arst_n clears the sphere table valid bits, the controller and the output valid,
// and sets step_limit 64, surface_threshold 66, far_limit 6553600.
module sphere_trace_ray_marcher_top import stm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index, center_x, center_y, center_z, sphere_size, origin_x, origin_y,
	// origin_z, heading_x, heading_y, heading_z
	input  logic [279:0] s_tdata,
	// kind
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_x, hit_y, hit_z, step_count, zero fill
	output logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	stm_cmd_t  cmd;
	stm_stat_t stat;
	logic signed [31:0] hit_x, hit_y, hit_z;
	logic [8:0] step_count;

	stm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	stm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.entry_index (s_tdata[2:0]),
		.center_x    (s_tdata[34:3]),
		.center_y    (s_tdata[66:35]),
		.center_z    (s_tdata[98:67]),
		.sphere_size (s_tdata[129:99]),
		.origin_x    (s_tdata[161:130]),
		.origin_y    (s_tdata[193:162]),
		.origin_z    (s_tdata[225:194]),
		.heading_x   (s_tdata[243:226]),
		.heading_y   (s_tdata[261:244]),
		.heading_z   (s_tdata[279:262]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.hit_z       (hit_z),
		.step_count  (step_count)
	);

	assign m_tdata = {7'd0, step_count, hit_z, hit_y, hit_x};

endmodule

@@ design/stm_dp.sv @@
// Datapath: config registers, sphere table, shared multiplier, bit-serial
// square root, distance compare and result register. Depends on stm_pkg.
module stm_dp import stm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stm_cmd_t           cmd,
	output stm_stat_t          stat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic [2:0]         entry_index,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        sphere_size,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [17:0] heading_x,
	input  logic signed [17:0] heading_y,
	input  logic signed [17:0] heading_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic [8:0]         step_count
);

	localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF;
	localparam logic signed [64:0] SAT_LO = -65'sh0_8000_0000;

	logic [7:0]  step_limit_q;
	logic [30:0] thr_q, far_q;

	logic signed [31:0] tcx_q [MAX_SPHERES];
	logic signed [31:0] tcy_q [MAX_SPHERES];
	logic signed [31:0] tcz_q [MAX_SPHERES];
	logic [30:0]        trad_q [MAX_SPHERES];
	logic [MAX_SPHERES-1:0] valid_q;

	logic signed [31:0] o_q [3];
	logic signed [17:0] h_q [3];
	logic signed [31:0] p_q [3];
	logic [30:0]        trav_q;

	logic [63:0] prod_q, sum_q, rem_q, root_q, bit_q;
	logic signed [33:0] best_q;

	logic               out_valid_q;
	logic signed [31:0] hx_q, hy_q, hz_q;
	logic [8:0]         cnt_q;

	logic [SLOT_W-1:0]  wslot;
	logic signed [31:0] c_sel;
	logic signed [32:0] off;
	logic [32:0]        mag_full;
	logic [31:0]        mag;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [63:0] shp;
	logic signed [64:0] psum;
	logic signed [31:0] psat;
	logic [63:0]        trial;
	logic signed [33:0] sph_d;
	logic signed [34:0] newt;

	assign wslot = SLOT_W'(entry_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= 8'd64;
			thr_q        <= 31'd66;
			far_q        <= 31'd6553600;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_LIMIT: step_limit_q <= cfg_data[7:0];
				CFG_THRESHOLD:  thr_q <= cfg_data;
				CFG_FAR_LIMIT:  far_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.ld_sph && (32'(entry_index) < MAX_SPHERES)) begin
			valid_q[wslot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_sph && (32'(entry_index) < MAX_SPHERES)) begin
			tcx_q[wslot]  <= center_x;
			tcy_q[wslot]  <= center_y;
			tcz_q[wslot]  <= center_z;
			trad_q[wslot] <= sphere_size;
		end
	end

	always_comb begin
		case (cmd.axis)
			2'd0:    c_sel = tcx_q[cmd.slot];
			2'd1:    c_sel = tcy_q[cmd.slot];
			default: c_sel = tcz_q[cmd.slot];
		endcase
	end

	// |p - c| clamped to 2^31 before squaring
	assign off      = {p_q[cmd.axis][31], p_q[cmd.axis]} - {c_sel[31], c_sel};
	assign mag_full = off[32] ? 33'(-off) : 33'(off);
	assign mag      = (mag_full > 33'h0_8000_0000) ? 32'h8000_0000 : mag_full[31:0];

	assign mul_a = cmd.sq_mul ? $signed({2'b00, mag})
		: $signed({{16{h_q[cmd.axis][17]}}, h_q[cmd.axis]});
	assign mul_b = cmd.sq_mul ? $signed({2'b00, mag}) : $signed({3'b000, trav_q});
	assign mul_p = mul_a * mul_b;

	assign shp  = $signed(prod_q) >>> FRAC_BITS;
	assign psum = $signed({{33{o_q[cmd.axis][31]}}, o_q[cmd.axis]}) + $signed({shp[63], shp});
	assign psat = (psum > SAT_HI) ? 32'sh7FFF_FFFF
		: (psum < SAT_LO) ? -32'sh8000_0000 : psum[31:0];

	assign trial = root_q + bit_q;
	assign sph_d = $signed({1'b0, root_q[32:0]}) - $signed({3'b000, trad_q[cmd.slot]});
	assign newt  = $signed({4'b0000, trav_q}) + $signed({best_q[33], best_q});

	always_ff @(posedge clk) begin
		if (cmd.ld_ray) begin
			o_q[0] <= origin_x;
			o_q[1] <= origin_y;
			o_q[2] <= origin_z;
			h_q[0] <= heading_x;
			h_q[1] <= heading_y;
			h_q[2] <= heading_z;
		end
		if (cmd.ld_ray)
			trav_q <= '0;
		else if (cmd.trav_upd)
			trav_q <= newt[30:0];
		if (cmd.pt_mul || cmd.sq_mul)
			prod_q <= mul_p[63:0];
		if (cmd.pt_wr)
			p_q[cmd.axis] <= psat;
		if (cmd.acc_clr)
			sum_q <= '0;
		else if (cmd.acc)
			sum_q <= sum_q + prod_q;
		if (cmd.root_init) begin
			rem_q  <= sum_q;
			root_q <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
		end else if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.best_init)
			best_q <= $signed({3'b000, far_q});
		else if (cmd.best_upd && (sph_d < best_q))
			best_q <= sph_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_wr)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			hx_q  <= p_q[0];
			hy_q  <= p_q[1];
			hz_q  <= p_q[2];
			cnt_q <= cmd.count;
		end
	end

	assign stat.slot_valid = valid_q[cmd.slot];
	assign stat.stop       = (best_q < $signed({3'b000, thr_q}))
		|| (newt > $signed({4'b0000, far_q}));
	assign stat.out_busy   = out_valid_q && !out_ready;
	assign stat.step_limit = step_limit_q;

	assign out_valid  = out_valid_q;
	assign hit_x      = hx_q;
	assign hit_y      = hy_q;
	assign hit_z      = hz_q;
	assign step_count = cnt_q;

`ifndef NO_ASSERTIONS
	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_step |-> $onehot(bit_q))
		else $error("square root bit not one-hot");
	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |=> out_valid_q)
		else $error("result not presented");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |-> !stat.out_busy)
		else $error("result overwritten");
`endif

endmodule

@@ design/stm_ctrl.sv @@
// Controller: takes sphere load words, and sequences point, per-sphere distance,
// square root and step decisions for one ray. Depends on stm_pkg.
module stm_ctrl import stm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      kind,
	input  stm_stat_t stat,
	output stm_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PMUL  = 4'd1;
	localparam logic [3:0] ST_PWR   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_SMUL  = 4'd4;
	localparam logic [3:0] ST_SACC  = 4'd5;
	localparam logic [3:0] ST_RINIT = 4'd6;
	localparam logic [3:0] ST_ROOT  = 4'd7;
	localparam logic [3:0] ST_RCMP  = 4'd8;
	localparam logic [3:0] ST_STEP  = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [3:0]        state_q, state_d;
	logic [1:0]        axis_q, axis_d;
	logic [K_W-1:0]    slot_q, slot_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic [8:0]        step_q, step_d;
	logic [8:0]        count_q, count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			slot_q  <= '0;
			iter_q  <= '0;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			slot_q  <= slot_d;
			iter_q  <= iter_d;
			step_q  <= step_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		slot_d  = slot_q;
		iter_d  = iter_q;
		step_d  = step_q;
		count_d = count_q;
		cmd     = '0;
		cmd.axis  = axis_q;
		cmd.slot  = slot_q[SLOT_W-1:0];
		cmd.count = count_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_RAY) begin
						cmd.ld_ray = 1'b1;
						axis_d  = '0;
						step_d  = '0;
						state_d = ST_PMUL;
					end else begin
						cmd.ld_sph = 1'b1;
					end
				end
			end
			ST_PMUL: begin
				cmd.pt_mul = 1'b1;
				state_d = ST_PWR;
			end
			ST_PWR: begin
				cmd.pt_wr = 1'b1;
				if (axis_q == 2'd2) begin
					cmd.best_init = 1'b1;
					slot_d  = '0;
					state_d = ST_SCAN;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_PMUL;
				end
			end
			ST_SCAN: begin
				if (slot_q == K_W'(MAX_SPHERES)) begin
					state_d = ST_STEP;
				end else if (!stat.slot_valid) begin
					slot_d = slot_q + 1'b1;
				end else begin
					cmd.acc_clr = 1'b1;
					axis_d  = '0;
					state_d = ST_SMUL;
				end
			end
			ST_SMUL: begin
				cmd.sq_mul = 1'b1;
				state_d = ST_SACC;
			end
			ST_SACC: begin
				cmd.acc = 1'b1;
				if (axis_q == 2'd2) begin
					state_d = ST_RINIT;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_SMUL;
				end
			end
			ST_RINIT: begin
				cmd.root_init = 1'b1;
				iter_d  = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == ITER_W'(ISQRT_STEPS - 1))
					state_d = ST_RCMP;
			end
			ST_RCMP: begin
				cmd.best_upd = 1'b1;
				slot_d  = slot_q + 1'b1;
				state_d = ST_SCAN;
			end
			ST_STEP: begin
				if (stat.stop) begin
					count_d = step_q;
					state_d = ST_DONE;
				end else if (step_q == {1'b0, stat.step_limit}) begin
					count_d = step_q + 9'd1;
					state_d = ST_DONE;
				end else begin
					cmd.trav_upd = 1'b1;
					step_d  = step_q + 9'd1;
					axis_d  = '0;
					state_d = ST_PMUL;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ray_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && kind == KIND_RAY) |=> state_q == ST_PMUL)
		else $error("ray did not start");
	a_root_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && iter_q == ITER_W'(ISQRT_STEPS - 1)) |=> state_q == ST_RCMP)
		else $error("square root length wrong");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !stat.out_busy) |=> state_q == ST_IDLE)
		else $error("result not handed off");
`endif

endmodule
